// ===== hdl/cfp_pkg.sv =====
// shared types, constants and helper functions for the countdown frame parser
// no dependencies; used by every other file of the block except cfp_stream_if

package cfp_pkg;

   // field widths
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CHANNEL_W = 3;
   localparam int unsigned COLOR_W   = 2;
   localparam int unsigned COUNT_W   = 15;
   localparam int unsigned POS_W     = 3;

   // byte positions within one frame
   localparam logic [POS_W-1:0] POS_HEADER  = 3'd0;
   localparam logic [POS_W-1:0] POS_CONTROL = 3'd1;
   localparam logic [POS_W-1:0] POS_HIGH    = 3'd2;
   localparam logic [POS_W-1:0] POS_LOW     = 3'd3;
   localparam logic [POS_W-1:0] POS_CHECK   = 3'd4;

   // light color codes
   localparam logic [COLOR_W-1:0] COLOR_DARK   = 2'd0;
   localparam logic [COLOR_W-1:0] COLOR_GREEN  = 2'd1;
   localparam logic [COLOR_W-1:0] COLOR_YELLOW = 2'd2;
   localparam logic [COLOR_W-1:0] COLOR_RED    = 2'd3;

   // control byte layout and checksum mask
   localparam int unsigned CTRL_TYPE_BIT  = 5;
   localparam int unsigned CTRL_CHAN_LSB  = 2;
   localparam logic [BYTE_W-1:0] CHECK_MASK = 8'h7f;

   // depth of the result queue
   localparam int unsigned RSP_DEPTH = 3;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              buffer_start;
   } req_payload_type;

   typedef struct packed {
      logic               checksum_ok;
      logic [COLOR_W-1:0] light_color;
      logic [COUNT_W-1:0] count_value;
      logic               display_type;
      logic [COUNT_W-1:0] green_count;
      logic [COUNT_W-1:0] yellow_count;
      logic [COUNT_W-1:0] red_count;
   } rsp_payload_type;

   // weighted sum of four bcd nibbles, thousands first, nibbles not range checked
   function automatic logic [COUNT_W-1:0] bcd_weight(input logic [BYTE_W-1:0] hi,
                                                     input logic [BYTE_W-1:0] lo);
      logic [COUNT_W-1:0] sum;
      sum = COUNT_W'(hi[7:4]) * COUNT_W'(1000) + COUNT_W'(hi[3:0]) * COUNT_W'(100)
          + COUNT_W'(lo[7:4]) * COUNT_W'(10) + COUNT_W'(lo[3:0]);
      return sum;
   endfunction

endpackage

// ===== hdl/cfp_stream_if.sv =====
// valid/ready stream interface carrying one payload word per handshake
// depends on nothing; payload type is chosen by the instantiating module

interface cfp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/cfp_frame_decoder.sv =====
// frame alignment, byte capture and checksum decode for one byte per cycle
// depends on cfp_pkg

module cfp_frame_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [cfp_pkg::CHANNEL_W-1:0]  my_channel,
   input  logic                           byte_valid,
   input  logic [cfp_pkg::BYTE_W-1:0]     rx_byte,
   input  logic                           buffer_start,
   output logic                           result_valid,
   output cfp_pkg::rsp_payload_type       result
);

   logic [cfp_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                        matched_ff, matched_in;
   logic [cfp_pkg::BYTE_W-1:0]  ctrl_ff, ctrl_in;
   logic [cfp_pkg::BYTE_W-1:0]  high_ff, high_in;
   logic [cfp_pkg::BYTE_W-1:0]  low_ff, low_in;
   logic [cfp_pkg::COUNT_W-1:0] green_ff, green_in;
   logic [cfp_pkg::COUNT_W-1:0] yellow_ff, yellow_in;
   logic [cfp_pkg::COUNT_W-1:0] red_ff, red_in;

   logic [cfp_pkg::POS_W-1:0]   pos_cur;
   logic                        matched_cur;
   logic [cfp_pkg::BYTE_W-1:0]  check_sum;
   logic                        sum_ok;
   logic [cfp_pkg::COUNT_W-1:0] count;
   logic [cfp_pkg::COLOR_W-1:0] color;

   // checksum and count from the captured bytes
   assign check_sum = (ctrl_ff ^ high_ff ^ low_ff) & cfp_pkg::CHECK_MASK;
   assign sum_ok    = (check_sum == rx_byte);
   assign count     = cfp_pkg::bcd_weight(high_ff, low_ff);
   assign color     = ctrl_ff[cfp_pkg::COLOR_W-1:0];

   // per-byte update of alignment, captured bytes and latches
   always_comb begin
      pos_cur      = buffer_start ? cfp_pkg::POS_HEADER : pos_ff;
      matched_cur  = buffer_start ? 1'b0 : matched_ff;
      pos_in       = pos_ff;
      matched_in   = matched_ff;
      ctrl_in      = ctrl_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      green_in     = green_ff;
      yellow_in    = yellow_ff;
      red_in       = red_ff;
      result_valid = 1'b0;
      result       = '0;
      if (byte_valid) begin
         matched_in = matched_cur;
         pos_in     = (pos_cur >= cfp_pkg::POS_CHECK) ? cfp_pkg::POS_HEADER
                                                      : pos_cur + 3'd1;
         unique case (pos_cur)
            cfp_pkg::POS_HEADER: begin
            end
            cfp_pkg::POS_CONTROL: begin
               ctrl_in = rx_byte;
            end
            cfp_pkg::POS_HIGH: begin
               high_in = rx_byte;
            end
            cfp_pkg::POS_LOW: begin
               low_in = rx_byte;
            end
            default: begin
               // checksum byte: first frame for our channel in this buffer
               if (!matched_cur &&
                   ctrl_ff[cfp_pkg::CTRL_CHAN_LSB +: cfp_pkg::CHANNEL_W] == my_channel) begin
                  matched_in   = 1'b1;
                  result_valid = 1'b1;
                  if (sum_ok) begin
                     unique case (color)
                        cfp_pkg::COLOR_GREEN:  green_in  = count;
                        cfp_pkg::COLOR_YELLOW: yellow_in = count;
                        cfp_pkg::COLOR_RED:    red_in    = count;
                        default: begin
                        end
                     endcase
                     result.checksum_ok  = 1'b1;
                     result.light_color  = color;
                     result.count_value  = count;
                     result.display_type = ctrl_ff[cfp_pkg::CTRL_TYPE_BIT];
                  end
                  result.green_count  = green_in;
                  result.yellow_count = yellow_in;
                  result.red_count    = red_in;
               end
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= cfp_pkg::POS_HEADER;
         matched_ff <= 1'b0;
         ctrl_ff    <= '0;
         high_ff    <= '0;
         low_ff     <= '0;
         green_ff   <= '0;
         yellow_ff  <= '0;
         red_ff     <= '0;
      end else begin
         pos_ff     <= pos_in;
         matched_ff <= matched_in;
         ctrl_ff    <= ctrl_in;
         high_ff    <= high_in;
         low_ff     <= low_in;
         green_ff   <= green_in;
         yellow_ff  <= yellow_in;
         red_ff     <= red_in;
      end
   end

   // frame position stays within one frame
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= cfp_pkg::POS_CHECK)
      else $error("frame position out of range");

   // a result marks the buffer as matched
   a_match_set: assert property (@(posedge clock) disable iff (reset)
      result_valid |=> matched_ff)
      else $error("buffer not marked matched after result");

   // a result only comes from the checksum byte of a frame
   a_result_pos: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> (byte_valid && !buffer_start && pos_ff == cfp_pkg::POS_CHECK))
      else $error("result outside checksum byte");

   // green and red latches change only on a passing checksum
   a_latch_hold: assert property (@(posedge clock) disable iff (reset)
      !(result_valid && result.checksum_ok) |=> $stable(green_ff) && $stable(red_ff))
      else $error("latch changed without a good frame");

endmodule

// ===== hdl/cfp_result_queue.sv =====
// small result queue decoupling the decoder from the result channel
// depends on cfp_pkg

module cfp_result_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  cfp_pkg::rsp_payload_type          push_data,
   output logic [cfp_pkg::RSP_CNT_W-1:0]     count,
   cfp_stream_if.source                      rsp_chan
);

   cfp_pkg::rsp_payload_type             mem_ff [cfp_pkg::RSP_DEPTH];
   logic [cfp_pkg::RSP_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [cfp_pkg::RSP_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [cfp_pkg::RSP_CNT_W-1:0]        cnt_ff, cnt_in;
   logic                                 pop;

   localparam logic [cfp_pkg::RSP_PTR_W-1:0] LAST_PTR =
      cfp_pkg::RSP_PTR_W'(cfp_pkg::RSP_DEPTH - 1);

   assign pop              = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.valid   = (cnt_ff != '0);
   assign rsp_chan.payload = mem_ff[rd_ptr_ff];
   assign count            = cnt_ff;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + cfp_pkg::RSP_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + cfp_pkg::RSP_PTR_W'(1);
      end
      priority if (push && !pop) begin
         cnt_in = cnt_ff + cfp_pkg::RSP_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - cfp_pkg::RSP_CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // never written while full, unless a word is popped in the same cycle
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff < cfp_pkg::RSP_CNT_W'(cfp_pkg::RSP_DEPTH) || pop))
      else $error("result queue overflow");

   // fill count stays in range
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= cfp_pkg::RSP_CNT_W'(cfp_pkg::RSP_DEPTH))
      else $error("result queue count out of range");

   // an empty queue has equal read and write pointers
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

endmodule

// ===== hdl/countdown_frame_parser_core.sv =====
// top level of the countdown frame parser: input register, decoder, result queue
// depends on cfp_pkg, cfp_stream_if, cfp_frame_decoder and cfp_result_queue

// Accepts one received byte per clock cycle, back to back while ready, and
// decodes 5-byte countdown frames aligned to the byte flagged buffer_start. The
// first complete frame of a buffer addressed to the channel held in the csr
// register gives one result word, through the input register and the decoder
// into a three-word result queue. The input is ready whenever the queue plus the
// byte in the input register leave room for another result, so a sink that
// takes results as they come never stalls the byte stream. The user must write
// the channel register only while the block is idle; this is not enforced.

module countdown_frame_parser_core (
   input  logic                          clock,
   input  logic                          reset,
   cfp_stream_if.sink                    req_chan,
   cfp_stream_if.source                  rsp_chan,
   input  logic                          csr_we,
   input  logic [cfp_pkg::CHANNEL_W-1:0] csr_wdata
);

   logic [cfp_pkg::CHANNEL_W-1:0] channel_ff;
   logic                          s1_valid_ff, s1_valid_in;
   logic [cfp_pkg::BYTE_W-1:0]    s1_byte_ff;
   logic                          s1_start_ff;
   logic                          req_accept;
   logic                          dec_valid;
   cfp_pkg::rsp_payload_type      dec_result;
   logic [cfp_pkg::RSP_CNT_W-1:0] queue_count;
   logic [cfp_pkg::RSP_CNT_W:0]   in_flight;

   // room check: queued results plus the byte in the input register
   assign in_flight      = {1'b0, queue_count} + (cfp_pkg::RSP_CNT_W + 1)'(s1_valid_ff);
   assign req_chan.ready = (in_flight < (cfp_pkg::RSP_CNT_W + 1)'(cfp_pkg::RSP_DEPTH));
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = req_accept;

   // channel register
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= '0;
      end else if (csr_we) begin
         channel_ff <= csr_wdata;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff  <= req_chan.payload.rx_byte;
         s1_start_ff <= req_chan.payload.buffer_start;
      end
   end

   cfp_frame_decoder u_decoder (
      .clock        (clock),
      .reset        (reset),
      .my_channel   (channel_ff),
      .byte_valid   (s1_valid_ff),
      .rx_byte      (s1_byte_ff),
      .buffer_start (s1_start_ff),
      .result_valid (dec_valid),
      .result       (dec_result)
   );

   cfp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (dec_valid),
      .push_data (dec_result),
      .count     (queue_count),
      .rsp_chan  (rsp_chan)
   );

   // queue and input register never hold more than the queue can take
   a_room: assert property (@(posedge clock) disable iff (reset)
      in_flight <= (cfp_pkg::RSP_CNT_W + 1)'(cfp_pkg::RSP_DEPTH))
      else $error("more words in flight than queue space");

   // the decoder sees a byte in the cycle after it is accepted
   a_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted byte did not reach the input register");

   // a result never appears without a byte in the input register
   a_dec_src: assert property (@(posedge clock) disable iff (reset)
      dec_valid |-> s1_valid_ff)
      else $error("decoder result without input byte");

endmodule

// ===== dv/cfp_frame_checker.sv =====
// frame checker for the countdown frame parser: tracks accepted bytes, predicts result words
// and compares them against what the block returns; depends on cfp_pkg only

module cfp_frame_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  cfp_pkg::req_payload_type      req_word,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  cfp_pkg::rsp_payload_type      rsp_word,
   input  logic                          csr_we,
   input  logic [cfp_pkg::CHANNEL_W-1:0] csr_wdata,
   output int                            mismatch_count,
   output int                            reports_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // mirrored parser state
   logic [cfp_pkg::CHANNEL_W-1:0] listen_chan;
   logic [cfp_pkg::POS_W-1:0]     frame_pos;
   logic [cfp_pkg::BYTE_W-1:0]    ctrl_q;
   logic [cfp_pkg::BYTE_W-1:0]    hi_q;
   logic [cfp_pkg::BYTE_W-1:0]    lo_q;
   logic                          buffer_hit;
   logic [cfp_pkg::COUNT_W-1:0]   green_q;
   logic [cfp_pkg::COUNT_W-1:0]   yellow_q;
   logic [cfp_pkg::COUNT_W-1:0]   red_q;

   // result words still owed by the block, oldest first
   cfp_pkg::rsp_payload_type frame_reports_due[$];

   // advance the frame tracker by one byte, queue a report when a frame closes
   task automatic track_frame_byte(input cfp_pkg::req_payload_type w);
      cfp_pkg::rsp_payload_type   report;
      logic [cfp_pkg::BYTE_W-1:0] sum;
      if (w.buffer_start) begin
         frame_pos  = cfp_pkg::POS_HEADER;
         buffer_hit = 1'b0;
      end
      case (frame_pos)
         cfp_pkg::POS_HEADER: ;
         cfp_pkg::POS_CONTROL: ctrl_q = w.rx_byte;
         cfp_pkg::POS_HIGH:    hi_q   = w.rx_byte;
         cfp_pkg::POS_LOW:     lo_q   = w.rx_byte;
         default: begin
            if (!buffer_hit &&
                ctrl_q[cfp_pkg::CTRL_CHAN_LSB +: cfp_pkg::CHANNEL_W] == listen_chan) begin
               buffer_hit = 1'b1;
               report     = '0;
               sum        = (ctrl_q ^ hi_q ^ lo_q) & cfp_pkg::CHECK_MASK;
               if (sum == w.rx_byte) begin
                  report.checksum_ok  = 1'b1;
                  report.light_color  = ctrl_q[cfp_pkg::COLOR_W-1:0];
                  // nibbles weighted as they are, no bcd range check
                  report.count_value  = cfp_pkg::COUNT_W'(1000 * int'(hi_q[7:4])
                                                          + 100 * int'(hi_q[3:0])
                                                          + 10 * int'(lo_q[7:4])
                                                          + int'(lo_q[3:0]));
                  report.display_type = ctrl_q[cfp_pkg::CTRL_TYPE_BIT];
                  case (report.light_color)
                     cfp_pkg::COLOR_GREEN:  green_q  = report.count_value;
                     cfp_pkg::COLOR_YELLOW: yellow_q = report.count_value;
                     cfp_pkg::COLOR_RED:    red_q    = report.count_value;
                     default: ;
                  endcase
               end
               report.green_count  = green_q;
               report.yellow_count = yellow_q;
               report.red_count    = red_q;
               frame_reports_due.push_back(report);
            end
         end
      endcase
      frame_pos = (frame_pos >= cfp_pkg::POS_CHECK) ? cfp_pkg::POS_HEADER
                                                    : frame_pos + cfp_pkg::POS_W'(1);
   endtask

   task automatic check_field(input string what, input logic [cfp_pkg::COUNT_W-1:0] want,
                              input logic [cfp_pkg::COUNT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // sample both channels and the csr port at each rising edge
   always @(posedge clock) begin
      cfp_pkg::rsp_payload_type want;
      if (reset) begin
         listen_chan = '0;
         frame_pos   = cfp_pkg::POS_HEADER;
         ctrl_q      = '0;
         hi_q        = '0;
         lo_q        = '0;
         buffer_hit  = 1'b0;
         green_q     = '0;
         yellow_q    = '0;
         red_q       = '0;
         frame_reports_due.delete();
      end else begin
         if (csr_we) begin
            listen_chan = csr_wdata;
         end
         if (req_valid && req_ready) begin
            track_frame_byte(req_word);
         end
         // compare a returned word against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (frame_reports_due.size() == 0) begin
               $display({"%0t: result word with nothing expected: expected none actual ",
                         "ok=%0b color=%0d count=%0d type=%0b g=%0d y=%0d r=%0d"},
                        $time, rsp_word.checksum_ok, rsp_word.light_color,
                        rsp_word.count_value, rsp_word.display_type, rsp_word.green_count,
                        rsp_word.yellow_count, rsp_word.red_count);
               mismatch_count++;
            end else begin
               want = frame_reports_due.pop_front();
               check_field("checksum_ok", cfp_pkg::COUNT_W'(want.checksum_ok),
                           cfp_pkg::COUNT_W'(rsp_word.checksum_ok));
               check_field("light_color", cfp_pkg::COUNT_W'(want.light_color),
                           cfp_pkg::COUNT_W'(rsp_word.light_color));
               check_field("count_value", want.count_value, rsp_word.count_value);
               check_field("display_type", cfp_pkg::COUNT_W'(want.display_type),
                           cfp_pkg::COUNT_W'(rsp_word.display_type));
               check_field("green_count", want.green_count, rsp_word.green_count);
               check_field("yellow_count", want.yellow_count, rsp_word.yellow_count);
               check_field("red_count", want.red_count, rsp_word.red_count);
            end
         end
      end
      reports_pending = frame_reports_due.size();
   end

endmodule

// ===== dv/countdown_frame_parser_core_tb.sv =====
// testbench top for the countdown frame parser: clock, reset, byte stimulus, result sink
// and verdict; depends on cfp_pkg, cfp_stream_if, the core and cfp_frame_checker

module countdown_frame_parser_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASE_WORDS = 232;

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [cfp_pkg::CHANNEL_W-1:0] csr_wdata;
   int                            mismatch_count;
   int                            reports_pending;
   int                            words_sent;
   int                            req_quiet;
   int                            rsp_quiet;

   cfp_stream_if #(.payload_type(cfp_pkg::req_payload_type)) req_if ();
   cfp_stream_if #(.payload_type(cfp_pkg::rsp_payload_type)) rsp_if ();

   countdown_frame_parser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   cfp_frame_checker frame_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_word        (req_if.payload),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_word        (rsp_if.payload),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .reports_pending (reports_pending)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // idle cycles before the next word, with runs of back to back words
   function automatic int draw_gap(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         quiet = $urandom_range(20, 80);
      end
      return $urandom_range(0, 17);
   endfunction

   function automatic logic [cfp_pkg::BYTE_W-1:0] ctrl_byte(
      input logic [1:0] spare, input logic dtype,
      input logic [cfp_pkg::CHANNEL_W-1:0] chan,
      input logic [cfp_pkg::COLOR_W-1:0] color);
      return {spare, dtype, chan, color};
   endfunction

   // drive one byte word and wait for its handshake
   task automatic send_word(input logic [cfp_pkg::BYTE_W-1:0] value, input logic start);
      int gap;
      gap = draw_gap(req_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.payload = '{rx_byte: value, buffer_start: start};
      req_if.valid   = 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
   endtask

   // full five byte frame, check byte optionally corrupted by flip
   task automatic send_frame(input logic start, input logic [cfp_pkg::BYTE_W-1:0] ctrl,
                             input logic [cfp_pkg::BYTE_W-1:0] hi,
                             input logic [cfp_pkg::BYTE_W-1:0] lo,
                             input logic [cfp_pkg::BYTE_W-1:0] flip);
      send_word(8'($urandom), start);
      send_word(ctrl, 1'b0);
      send_word(hi, 1'b0);
      send_word(lo, 1'b0);
      send_word(((ctrl ^ hi ^ lo) & cfp_pkg::CHECK_MASK) ^ flip, 1'b0);
   endtask

   // drain the block, then write the channel register
   task automatic set_channel(input logic [cfp_pkg::CHANNEL_W-1:0] chan);
      @(negedge clock);
      req_if.valid = 1'b0;
      while (reports_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = chan;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // one receive buffer: mostly well formed frames, some noise and cut frames
   task automatic send_random_buffer(input logic [cfp_pkg::CHANNEL_W-1:0] chan);
      int                            nframes;
      int                            nbytes;
      logic [cfp_pkg::CHANNEL_W-1:0] frame_chan;
      logic [cfp_pkg::BYTE_W-1:0]    hi;
      logic [cfp_pkg::BYTE_W-1:0]    lo;
      logic [cfp_pkg::BYTE_W-1:0]    flip;
      if ($urandom_range(0, 9) == 0) begin
         // noise with stray buffer starts
         nbytes = $urandom_range(1, 12);
         for (int i = 0; i < nbytes; i++) begin
            send_word(8'($urandom), (i == 0) || ($urandom_range(0, 5) == 0));
         end
         return;
      end
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
         frame_chan = ($urandom_range(0, 3) != 0) ? chan : cfp_pkg::CHANNEL_W'($urandom);
         if ($urandom_range(0, 3) == 0) begin
            hi = 8'($urandom);
            lo = 8'($urandom);
         end else begin
            hi = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            lo = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
         end
         flip = ($urandom_range(0, 6) == 0) ? cfp_pkg::BYTE_W'(1 << $urandom_range(0, 7))
                                            : '0;
         send_frame(f == 0, ctrl_byte(2'($urandom), 1'($urandom), frame_chan,
                                      cfp_pkg::COLOR_W'($urandom)), hi, lo, flip);
      end
      // trailing frame cut short
      if ($urandom_range(0, 4) == 0) begin
         nbytes = $urandom_range(1, 4);
         for (int i = 0; i < nbytes; i++) begin
            send_word(8'($urandom), 1'b0);
         end
      end
   endtask

   // byte stimulus and verdict
   initial begin
      logic [cfp_pkg::CHANNEL_W-1:0] phase_chan;
      int                            target;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      words_sent     = 0;
      req_quiet      = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_channel(3'd0);
      // frame ahead of any buffer start, all nibbles 0xf, type bit set
      send_frame(1'b0, ctrl_byte(2'b00, 1'b1, 3'd0, cfp_pkg::COLOR_GREEN),
                 8'hff, 8'hff, 8'h00);
      // new buffer: yellow zero with spare bits set, then a frame that must be ignored
      send_frame(1'b1, ctrl_byte(2'b11, 1'b0, 3'd0, cfp_pkg::COLOR_YELLOW),
                 8'h00, 8'h00, 8'h00);
      send_frame(1'b0, ctrl_byte(2'b00, 1'b1, 3'd0, cfp_pkg::COLOR_RED),
                 8'h12, 8'h34, 8'h00);
      // frame cut by the next buffer start
      send_word(8'hff, 1'b1);
      send_word(ctrl_byte(2'b00, 1'b0, 3'd0, cfp_pkg::COLOR_RED), 1'b0);
      // checksum mismatch in bit 7 only
      send_frame(1'b1, ctrl_byte(2'b00, 1'b1, 3'd0, cfp_pkg::COLOR_RED),
                 8'h98, 8'h76, 8'h80);
      // dark frame still reports its count
      send_frame(1'b1, ctrl_byte(2'b00, 1'b0, 3'd0, cfp_pkg::COLOR_DARK),
                 8'h99, 8'h99, 8'h00);

      // random phases over several channel settings, extremes included
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       phase_chan = 3'd7;
            1:       phase_chan = 3'd3;
            2:       phase_chan = 3'd0;
            3:       phase_chan = 3'd5;
            4:       phase_chan = cfp_pkg::CHANNEL_W'($urandom);
            default: phase_chan = 3'd7;
         endcase
         set_channel(phase_chan);
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) send_random_buffer(phase_chan);
      end

      @(negedge clock);
      req_if.valid = 1'b0;
      while (reports_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // result sink with random stalls
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      rsp_quiet    = 0;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap(rsp_quiet);
         @(negedge clock);
         if (gap > 0) begin
            rsp_if.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/cfp_pkg.sv
hdl/cfp_stream_if.sv
hdl/cfp_frame_decoder.sv
hdl/cfp_result_queue.sv
hdl/countdown_frame_parser_core.sv
dv/cfp_frame_checker.sv
dv/countdown_frame_parser_core_tb.sv
